FILE: hdl/mm3_pkg.sv
// shared types, constants and codes for the murmur3 byte stream hash
package mm3_pkg;

  localparam logic [31:0] MUR_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2   = 32'h1b873593;
  localparam logic [31:0] MUR_ADD  = 32'he6546b64;
  localparam logic [31:0] MUR_F1   = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2   = 32'hc2b2ae35;
  localparam logic [31:0] MUR_MUL5 = 32'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HX,
    ST_HA,
    ST_T1,
    ST_T2,
    ST_TX,
    ST_F0,
    ST_F1,
    ST_F2
  } mm3_state_t;

  typedef enum logic [2:0] {
    MC_C1,
    MC_C2,
    MC_FIVE,
    MC_F1,
    MC_F2
  } mm3_mconst_t;

  typedef enum logic [2:0] {
    OA_BLOCK,
    OA_ROT15,
    OA_HROT,
    OA_PEND,
    OA_FIN0,
    OA_FIN1
  } mm3_opsel_t;

  typedef enum logic [1:0] {
    H_HOLD,
    H_ADD,
    H_XOR
  } mm3_hop_t;

  typedef struct packed {
    logic        blk;
    logic        last_in;
    logic        tail_nz;
    logic        last_r;
    logic        out_free;
  } mm3_stat_t;

  typedef struct packed {
    logic        take;
    logic        mul_en;
    mm3_opsel_t  op_sel;
    mm3_mconst_t mconst;
    mm3_hop_t    h_op;
    logic        out_ld;
  } mm3_ctl_t;

endpackage

FILE: hdl/murmur3_32_byte_stream_hash.sv
// top level: byte packing, running hash state, output register
// bytes are taken in idle; a byte that completes a block then runs K1, K2, HX, HA
// a last item adds finalizer F0, F1, F2, after T1, T2, TX if 1 to 3 tail bytes remain
// no item is taken until back in idle; all products share one 32x32 multiplier
// the result waits in an output register; the next message's bytes are taken meanwhile
// reset (rst_n low, synchronous) clears the hash state, sequencer and output valid
module murmur3_32_byte_stream_hash
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] no_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] hash_value
);

  mm3_stat_t   stat;
  mm3_ctl_t    ctl;
  logic [31:0] h_r;
  logic [23:0] pend_r;
  logic [1:0]  phase_r;
  logic [31:0] len_r;
  logic [31:0] blk_r;
  logic        last_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] mul_a;
  logic [31:0] mul_p;
  logic [31:0] hx;
  logic [31:0] fx;
  logic        has_byte;

  assign has_byte = !in_tuser;

  assign stat.blk      = has_byte && (phase_r == 2'd3);
  assign stat.last_in  = in_tlast;
  assign stat.tail_nz  = has_byte ? (phase_r != 2'd3) : (phase_r != 2'd0);
  assign stat.last_r   = last_r;
  assign stat.out_free = !out_valid_r || out_tready;

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  assign hx = h_r ^ mul_p;
  assign fx = h_r ^ len_r;

  always_comb begin
    unique case (ctl.op_sel)
      OA_BLOCK: mul_a = blk_r;
      OA_ROT15: mul_a = {mul_p[16:0], mul_p[31:17]};
      OA_HROT:  mul_a = {hx[18:0], hx[31:19]};
      OA_PEND:  mul_a = {8'd0, pend_r};
      OA_FIN0:  mul_a = fx ^ {16'd0, fx[31:16]};
      OA_FIN1:  mul_a = mul_p ^ {13'd0, mul_p[31:13]};
      default:  mul_a = blk_r;
    endcase
  end

  mm3_mul u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .a    (mul_a),
    .csel (ctl.mconst),
    .p    (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r     <= '0;
      pend_r  <= '0;
      phase_r <= '0;
      len_r   <= '0;
      last_r  <= 1'b0;
    end else if (ctl.out_ld) begin
      h_r     <= '0;
      pend_r  <= '0;
      phase_r <= '0;
      len_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      if (ctl.take) begin
        last_r <= in_tlast;
        if (has_byte) begin
          len_r <= len_r + 32'd1;
          unique case (phase_r)
            2'd0: pend_r[7:0]   <= in_tdata;
            2'd1: pend_r[15:8]  <= in_tdata;
            2'd2: pend_r[23:16] <= in_tdata;
            2'd3: pend_r        <= '0;
            default: ;
          endcase
          phase_r <= phase_r + 2'd1;
        end
      end
      unique case (ctl.h_op)
        H_HOLD: ;
        H_ADD:  h_r <= mul_p + MUR_ADD;
        H_XOR:  h_r <= hx;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && has_byte && phase_r == 2'd3) begin
      blk_r <= {in_tdata, pend_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_data_r <= mul_p ^ {16'd0, mul_p[31:16]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ast_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_ld |=> (len_r == 32'd0 && phase_r == 2'd0 && h_r == 32'd0))
    else $error("state not cleared after result");

  ast_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.out_ld))
    else $error("output valid without a finished hash");

  ast_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_ld |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  ast_take_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |-> (ctl.h_op == H_HOLD && !ctl.mul_en))
    else $error("byte taken while datapath busy");

endmodule

FILE: hdl/mm3_mul.sv
// shared 32x32 multiplier, low word, against a selected constant, registered
module mm3_mul
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  mm3_mconst_t csel,
  output logic [31:0] p
);

  logic [31:0] b;
  logic [31:0] p_r;

  always_comb begin
    unique case (csel)
      MC_C1:   b = MUR_C1;
      MC_C2:   b = MUR_C2;
      MC_FIVE: b = MUR_MUL5;
      MC_F1:   b = MUR_F1;
      MC_F2:   b = MUR_F2;
      default: b = MUR_C1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

FILE: hdl/mm3_ctrl.sv
// sequencer that steps the shared multiplier through block, tail and finalizer
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  mm3_stat_t stat,
  output logic      in_tready,
  output mm3_ctl_t  ctl
);

  mm3_state_t state_r;
  mm3_state_t state_nxt;
  logic       take;

  assign in_tready = (state_r == ST_IDLE);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          priority if (stat.blk) begin
            state_nxt = ST_K1;
          end else if (stat.last_in && stat.tail_nz) begin
            state_nxt = ST_T1;
          end else if (stat.last_in) begin
            state_nxt = ST_F0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_K1: state_nxt = ST_K2;
      ST_K2: state_nxt = ST_HX;
      ST_HX: state_nxt = ST_HA;
      ST_HA: state_nxt = stat.last_r ? ST_F0 : ST_IDLE;
      ST_T1: state_nxt = ST_T2;
      ST_T2: state_nxt = ST_TX;
      ST_TX: state_nxt = ST_F0;
      ST_F0: state_nxt = ST_F1;
      ST_F1: state_nxt = ST_F2;
      ST_F2: state_nxt = stat.out_free ? ST_IDLE : ST_F2;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.take   = take;
    ctl.op_sel = OA_BLOCK;
    ctl.mconst = MC_C1;
    ctl.h_op   = H_HOLD;
    unique case (state_r)
      ST_IDLE: ;
      ST_K1: begin
        ctl.mul_en = 1'b1;
        ctl.op_sel = OA_BLOCK;
        ctl.mconst = MC_C1;
      end
      ST_K2, ST_T2: begin
        ctl.mul_en = 1'b1;
        ctl.op_sel = OA_ROT15;
        ctl.mconst = MC_C2;
      end
      ST_HX: begin
        ctl.mul_en = 1'b1;
        ctl.op_sel = OA_HROT;
        ctl.mconst = MC_FIVE;
      end
      ST_HA: ctl.h_op = H_ADD;
      ST_T1: begin
        ctl.mul_en = 1'b1;
        ctl.op_sel = OA_PEND;
        ctl.mconst = MC_C1;
      end
      ST_TX: ctl.h_op = H_XOR;
      ST_F0: begin
        ctl.mul_en = 1'b1;
        ctl.op_sel = OA_FIN0;
        ctl.mconst = MC_F1;
      end
      ST_F1: begin
        ctl.mul_en = 1'b1;
        ctl.op_sel = OA_FIN1;
        ctl.mconst = MC_F2;
      end
      ST_F2: ctl.out_ld = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  ast_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input taken while sequencer busy");

  ast_fin_from_f1: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F2 && $past(state_r) != ST_F2) |-> $past(state_r) == ST_F1)
    else $error("finalizer output entered out of order");

  ast_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F2) |-> !ctl.mul_en)
    else $error("multiplier disturbed while result pending");

endmodule
